// ===== hdl/histogram_largest_rectangle_defines.svh =====
// Assertion macros shared by the histogram block.
`ifndef HISTOGRAM_LARGEST_RECTANGLE_DEFINES_SVH
`define HISTOGRAM_LARGEST_RECTANGLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hlr_pkg.sv =====
`timescale 1ns / 1ps

package hlr_pkg;

  localparam int unsigned BAR_HEIGHT_W = 16;
  localparam int unsigned AREA_W       = 26;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } hlr_state_e;

endpackage

// ===== hdl/hlr_stack_mem.sv =====
`timescale 1ns / 1ps

module hlr_stack_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 26
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/hlr_area_unit.sv =====
`timescale 1ns / 1ps

module hlr_area_unit
  import hlr_pkg::*;
#(
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [HEIGHT_BITS-1:0] height_i,
  input  logic [CNT_W-1:0]       width_i,
  input  logic                   clear_i,
  output logic [AREA_W-1:0]      best_o,
  output logic                   busy_o
);

  localparam int unsigned PROD_W = HEIGHT_BITS + CNT_W;
  localparam int unsigned CMP_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

  logic              p_valid_q;
  logic [PROD_W-1:0] prod_q;
  logic [CMP_W-1:0]  prod_ext;
  logic [AREA_W-1:0] area_sat;
  logic [AREA_W-1:0] best_d, best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= PROD_W'(height_i) * PROD_W'(width_i);
    end
  end

  // Areas that do not fit the result field saturate before the compare.
  always_comb begin
    prod_ext = CMP_W'(prod_q);
    if (prod_ext > CMP_W'(AREA_MAX)) begin
      area_sat = AREA_MAX;
    end else begin
      area_sat = prod_ext[AREA_W-1:0];
    end
    best_d = best_q;
    if (clear_i) begin
      best_d = '0;
    end else if (p_valid_q && (area_sat > best_q)) begin
      best_d = area_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;
  assign busy_o = p_valid_q;

endmodule

// ===== hdl/histogram_largest_rectangle.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// -------   --------------------   ------------------------------
// input     in_valid_i/in_ready_o  bar_height_i, last_bar_i
// output    out_valid_o/out_ready_i max_area_o, too_many_bars_o
//
// A bar is compared with the stack top, pops each entry that is not lower
// and then is pushed; each stack read is overlapped with the next compare.
// A last bar then pops every entry left on the stack, waits for the area
// multiplier and maximum register, and then the result is loaded.
// Reset clears the counters and the best area; the stack memory needs no
// clearing pass because the fill count guards every read.
// The input is ready only in idle; it stalls during scan, drain and done.

`include "histogram_largest_rectangle_defines.svh"

module histogram_largest_rectangle
  import hlr_pkg::*;
#(
  parameter int unsigned MAX_BARS    = 1024,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [BAR_HEIGHT_W-1:0] bar_height_i,
  input  logic                    last_bar_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [AREA_W-1:0]       max_area_o,
  output logic                    too_many_bars_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_BARS);
  localparam int unsigned CNT_W  = $clog2(MAX_BARS + 1);
  localparam int unsigned DATA_W = HEIGHT_BITS + ADDR_W;

  hlr_state_e state_d, state_q;

  logic [HEIGHT_BITS-1:0] h_d, h_q;
  logic                   last_d, last_q;
  logic [ADDR_W-1:0]      start_d, start_q;
  logic [CNT_W-1:0]       count_d, count_q;
  logic [CNT_W-1:0]       bar_idx_d, bar_idx_q;
  logic                   ovf_d, ovf_q;
  logic                   rd_pend_d, rd_pend_q;
  logic [HEIGHT_BITS-1:0] cache_h_d, cache_h_q;
  logic [ADDR_W-1:0]      cache_s_d, cache_s_q;
  logic                   out_valid_d, out_valid_q;
  logic [AREA_W-1:0]      area_out_d, area_out_q;
  logic                   ovf_out_d, ovf_out_q;

  logic [31:0]            h_wide;
  logic [HEIGHT_BITS-1:0] top_h;
  logic [ADDR_W-1:0]      top_s;
  logic                   have_top;
  logic                   pop;
  logic                   push;
  logic                   accept;
  logic [CNT_W-1:0]       cnt_m2;
  logic [DATA_W-1:0]      rd_data;
  logic                   rd_en;
  logic [AREA_W-1:0]      best;
  logic                   area_busy;
  logic                   area_clear;
  logic [CNT_W-1:0]       pop_width;

  hlr_stack_mem #(
    .DEPTH  (MAX_BARS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i ({h_q, start_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_m2[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  hlr_area_unit #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .CNT_W       (CNT_W)
  ) u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pop),
    .height_i (top_h),
    .width_i  (pop_width),
    .clear_i  (area_clear),
    .best_o   (best),
    .busy_o   (area_busy)
  );

  assign h_wide = {16'b0, bar_height_i};

  // The top entry comes from the memory in the cycle after a pop read it,
  // and from the cache otherwise. Pushes only ever land above the entries
  // that can be read, so no forwarding is needed.
  assign top_h     = rd_pend_q ? rd_data[DATA_W-1 -: HEIGHT_BITS] : cache_h_q;
  assign top_s     = rd_pend_q ? rd_data[ADDR_W-1:0] : cache_s_q;
  assign have_top  = (count_q != '0);
  assign pop       = ((state_q == S_SCAN) && have_top && (top_h >= h_q)) ||
                     ((state_q == S_DRAIN) && have_top);
  assign push      = (state_q == S_SCAN) && !pop && (count_q < CNT_W'(MAX_BARS));
  assign cnt_m2    = count_q - CNT_W'(2);
  assign rd_en     = pop && (count_q >= CNT_W'(2));
  assign pop_width = bar_idx_q - CNT_W'(top_s);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    last_d      = last_q;
    start_d     = start_q;
    count_d     = count_q;
    bar_idx_d   = bar_idx_q;
    ovf_d       = ovf_q;
    rd_pend_d   = 1'b0;
    cache_h_d   = top_h;
    cache_s_d   = top_s;
    out_valid_d = out_valid_q;
    area_out_d  = area_out_q;
    ovf_out_d   = ovf_out_q;
    area_clear  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      count_d   = count_q - CNT_W'(1);
      start_d   = top_s;
      rd_pend_d = rd_en;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          h_d     = h_wide[HEIGHT_BITS-1:0];
          last_d  = last_bar_i;
          start_d = bar_idx_q[ADDR_W-1:0];
          if (bar_idx_q == CNT_W'(MAX_BARS)) begin
            ovf_d   = 1'b1;
            state_d = last_bar_i ? S_DRAIN : S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!pop) begin
          if (push) begin
            count_d   = count_q + CNT_W'(1);
            cache_h_d = h_q;
            cache_s_d = start_q;
          end
          bar_idx_d = bar_idx_q + CNT_W'(1);
          state_d   = last_q ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        // Wait for the last area to reach the maximum register.
        if (!have_top && !area_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          area_out_d  = ovf_q ? '0 : best;
          ovf_out_d   = ovf_q;
          area_clear  = 1'b1;
          count_d     = '0;
          bar_idx_d   = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bar_idx_q   <= '0;
      ovf_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bar_idx_q   <= bar_idx_d;
      ovf_q       <= ovf_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    last_q     <= last_d;
    start_q    <= start_d;
    cache_h_q  <= cache_h_d;
    cache_s_q  <= cache_s_d;
    area_out_q <= area_out_d;
    ovf_out_q  <= ovf_out_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign max_area_o      = area_out_q;
  assign too_many_bars_o = ovf_out_q;

  `HLR_ASSERT_NOW(a_count_le_bars, clk_i, rst_ni, 1'b1, count_q <= bar_idx_q, "stack deeper than bar count")
  `HLR_ASSERT_NOW(a_done_empty, clk_i, rst_ni, state_q == S_DONE, !have_top && !area_busy, "result taken before drain finished")
  `HLR_ASSERT_NEXT(a_ovf_flag, clk_i, rst_ni, accept && (bar_idx_q == CNT_W'(MAX_BARS)), ovf_q || out_valid_q, "excess bar not flagged")
  `HLR_ASSERT_NOW(a_ovf_zero, clk_i, rst_ni, out_valid_q && ovf_out_q, area_out_q == '0, "overflow result carries an area")

endmodule
